@@ src/jpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jpd_pkg;

    localparam int NUM_JOINTS_DEF = 12;

    // ramp progress quotient is 16 bits, one bit per divider step
    localparam int DIV_STEPS = 16;

    // input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_KP      = 3'd0;
    localparam logic [2:0] REG_KD      = 3'd1;
    localparam logic [2:0] REG_RAMP    = 3'd2;
    localparam logic [2:0] REG_ABDUCT  = 3'd3;
    localparam logic [2:0] REG_FLEX    = 3'd4;
    localparam logic [2:0] REG_KNEE    = 3'd5;
    localparam logic [2:0] REG_GRAVITY = 3'd6;
    localparam logic [2:0] REG_LIMIT   = 3'd7;

    localparam logic [15:0]        KP_RESET      = 16'd3840;
    localparam logic [15:0]        KD_RESET      = 16'd3072;
    localparam logic [15:0]        RAMP_RESET    = 16'd1000;
    localparam logic [14:0]        ABDUCT_RESET  = 15'd819;
    localparam logic signed [15:0] FLEX_RESET    = 16'sd2949;
    localparam logic signed [15:0] KNEE_RESET    = -16'sd5898;
    localparam logic signed [15:0] GRAVITY_RESET = 16'sd1271;
    localparam logic [14:0]        LIMIT_RESET   = 15'd8576;

    // joint roles within one leg
    localparam logic [1:0] PART_ABDUCT = 2'd0;
    localparam logic [1:0] PART_FLEX   = 2'd1;
    localparam logic [1:0] PART_KNEE   = 2'd2;

    typedef struct packed {
        logic [15:0]        kp_gain;
        logic [15:0]        kd_gain;
        logic [15:0]        ramp_ticks;
        logic [14:0]        abduct_target;
        logic signed [15:0] flex_target;
        logic signed [15:0] knee_target;
        logic signed [15:0] gravity_torque;
        logic [14:0]        torque_limit;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic calc_p2;
        logic calc_s;
        logic joint_first;
        logic stage_a;
        logic stage_b;
        logic stage_c;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic tick_go;
        logic last_joint;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

@@ src/joint_pd_ramp_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// sample transfer: a new item can follow in the next cycle while no tick is being worked
// tick transfer: serial divider steps, the easing square and scale multiplies, then the
// four-stage joint multiply chain for each joint in turn; each torque is loaded into the
// output register, and the chain holds while that register is full and stalled; after
// the last joint the block returns to idle and takes the next transfer
// reset: gains and targets to defaults, stored samples to zero, pose not captured

module joint_pd_ramp_controller
    import jpd_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic               kind,
    input  wire logic [3:0]         joint_index,
    input  wire logic signed [15:0] joint_position,
    input  wire logic signed [15:0] joint_velocity,
    input  wire logic               message_end,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [3:0]              torque_joint,
    output logic signed [15:0]      torque,
    output logic                    last_torque,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    jpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jpd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    jpd_datapath #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .joint_index    (joint_index),
        .joint_position (joint_position),
        .joint_velocity (joint_velocity),
        .message_end    (message_end),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .torque_joint   (torque_joint),
        .torque         (torque),
        .last_torque    (last_torque)
    );

endmodule

`default_nettype wire

@@ src/jpd_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jpd_regs
    import jpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain        <= KP_RESET;
            cfg_reg.kd_gain        <= KD_RESET;
            cfg_reg.ramp_ticks     <= RAMP_RESET;
            cfg_reg.abduct_target  <= ABDUCT_RESET;
            cfg_reg.flex_target    <= FLEX_RESET;
            cfg_reg.knee_target    <= KNEE_RESET;
            cfg_reg.gravity_torque <= GRAVITY_RESET;
            cfg_reg.torque_limit   <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_KP:      cfg_reg.kp_gain        <= pwdata[15:0];
                REG_KD:      cfg_reg.kd_gain        <= pwdata[15:0];
                REG_RAMP:    cfg_reg.ramp_ticks     <= pwdata[15:0];
                REG_ABDUCT:  cfg_reg.abduct_target  <= pwdata[14:0];
                REG_FLEX:    cfg_reg.flex_target    <= $signed(pwdata[15:0]);
                REG_KNEE:    cfg_reg.knee_target    <= $signed(pwdata[15:0]);
                REG_GRAVITY: cfg_reg.gravity_torque <= $signed(pwdata[15:0]);
                REG_LIMIT:   cfg_reg.torque_limit   <= pwdata[14:0];
                default:     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KP:      prdata = {16'h0, cfg_reg.kp_gain};
            REG_KD:      prdata = {16'h0, cfg_reg.kd_gain};
            REG_RAMP:    prdata = {16'h0, cfg_reg.ramp_ticks};
            REG_ABDUCT:  prdata = {17'h0, cfg_reg.abduct_target};
            REG_FLEX:    prdata = {16'h0, cfg_reg.flex_target};
            REG_KNEE:    prdata = {16'h0, cfg_reg.knee_target};
            REG_GRAVITY: prdata = {16'h0, cfg_reg.gravity_torque};
            REG_LIMIT:   prdata = {17'h0, cfg_reg.torque_limit};
            default:     prdata = 32'h0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/jpd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jpd_ctrl
    import jpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    sample_valid,
    output logic         sample_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam int DCW = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQ,
        ST_SM,
        ST_JA,
        ST_JB,
        ST_JC,
        ST_JD
    } state_t;

    state_t         state_reg;
    logic [DCW-1:0] div_cnt_reg;

    assign sample_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: cmd.accept = sample_valid;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_SQ:   cmd.calc_p2 = 1'b1;
            ST_SM:
            begin
                cmd.calc_s      = 1'b1;
                cmd.joint_first = 1'b1;
            end
            ST_JA:   cmd.stage_a = 1'b1;
            ST_JB:   cmd.stage_b = 1'b1;
            ST_JC:   cmd.stage_c = 1'b1;
            ST_JD:   cmd.out_load = !status.out_busy;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    div_cnt_reg <= '0;
                    if (sample_valid && status.tick_go)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DCW'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: state_reg <= ST_SM;
                ST_SM: state_reg <= ST_JA;
                ST_JA: state_reg <= ST_JB;
                ST_JB: state_reg <= ST_JC;
                ST_JC: state_reg <= ST_JD;
                ST_JD:
                begin
                    // hold while the output register is still full and the receiver stalls
                    if (!status.out_busy)
                    begin
                        state_reg <= status.last_joint ? ST_IDLE : ST_JA;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/jpd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jpd_datapath
    import jpd_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic               kind,
    input  wire logic [3:0]         joint_index,
    input  wire logic signed [15:0] joint_position,
    input  wire logic signed [15:0] joint_velocity,
    input  wire logic               message_end,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [3:0]              torque_joint,
    output logic signed [15:0]      torque,
    output logic                    last_torque
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int IW = (JW > 4) ? JW : 4;
    localparam logic signed [55:0] ROUND_HALF = 56'sd134217728;

    // joint stores
    logic signed [15:0] pos_reg   [NUM_JOINTS];
    logic signed [15:0] vel_reg   [NUM_JOINTS];
    logic signed [15:0] start_reg [NUM_JOINTS];
    logic               captured_reg;
    logic [15:0]        count_reg;

    // ramp progress
    logic        bypass_reg;
    logic [15:0] rem_reg;
    logic [15:0] quo_reg;
    logic [16:0] p2_reg;
    logic [16:0] s_reg;

    // joint sequencing
    logic [JW-1:0] joint_reg;
    logic [1:0]    part_reg;
    logic [1:0]    leg_reg;

    // per-joint pipeline
    logic signed [34:0] mul1_reg;
    logic signed [16:0] dpos_reg;
    logic signed [32:0] kdv_reg;
    logic signed [35:0] err_reg;
    logic signed [52:0] kpe_reg;

    // output register
    logic               out_valid_reg;
    logic [3:0]         out_joint_reg;
    logic signed [15:0] out_torque_reg;
    logic               out_last_reg;

    logic [IW-1:0] idx_w;
    logic [JW-1:0] waddr;
    logic          wr_en;
    logic          capture;
    logic          tick_start;

    logic [16:0]        r2;
    logic               r_ge;
    logic [16:0]        r_sub;
    logic [16:0]        p_val;
    logic [33:0]        sq_prod;
    logic [17:0]        ease_f;
    logic [34:0]        s_prod;

    logic signed [15:0] st;
    logic signed [15:0] pos;
    logic signed [15:0] vel;
    logic signed [15:0] stand;
    logic signed [16:0] diff;
    logic signed [34:0] mul1_next;
    logic signed [16:0] dpos_next;
    logic signed [32:0] kdv_next;
    logic signed [35:0] err_next;
    logic signed [52:0] kpe_next;
    logic signed [43:0] grav;
    logic signed [55:0] acc;
    logic signed [27:0] t_raw;
    logic signed [27:0] lim;
    logic signed [15:0] t_sat;
    logic               last_joint;

    assign idx_w      = IW'(joint_index);
    assign waddr      = idx_w[JW-1:0];
    assign wr_en      = cmd.accept && (kind == KIND_SAMPLE) && (idx_w < IW'(NUM_JOINTS));
    assign capture    = cmd.accept && (kind == KIND_SAMPLE) && message_end && !captured_reg;
    assign tick_start = cmd.accept && (kind == KIND_TICK) && captured_reg;
    assign last_joint = (joint_reg == JW'(NUM_JOINTS - 1));

    assign status.tick_go    = (kind == KIND_TICK) && captured_reg;
    assign status.last_joint = last_joint;
    assign status.out_busy   = out_valid_reg && result_stall;

    assign result_valid = out_valid_reg;
    assign torque_joint = out_joint_reg;
    assign torque       = out_torque_reg;
    assign last_torque  = out_last_reg;

    // restoring divider, count < ramp_ticks so the quotient fits 16 bits
    assign r2    = {rem_reg, 1'b0};
    assign r_ge  = (r2 >= {1'b0, cfg.ramp_ticks});
    assign r_sub = r2 - {1'b0, cfg.ramp_ticks};

    assign p_val   = bypass_reg ? 17'h10000 : {1'b0, quo_reg};
    assign sq_prod = p_val * p_val;
    assign ease_f  = 18'h30000 - {p_val, 1'b0};
    assign s_prod  = p2_reg * ease_f;

    assign st  = start_reg[joint_reg];
    assign pos = pos_reg[joint_reg];
    assign vel = vel_reg[joint_reg];

    always_comb
    begin
        unique case (part_reg)
            PART_ABDUCT:
            begin
                // left legs take the negated magnitude
                if (leg_reg[1])
                begin
                    stand = $signed({1'b0, cfg.abduct_target});
                end
                else
                begin
                    stand = -$signed({1'b0, cfg.abduct_target});
                end
            end
            PART_FLEX: stand = cfg.flex_target;
            PART_KNEE: stand = cfg.knee_target;
            default:   stand = '0;
        endcase
    end

    always_comb
    begin
        unique case (part_reg)
            PART_FLEX: grav = $signed({cfg.gravity_torque, 28'h0});
            PART_KNEE: grav = -$signed({cfg.gravity_torque[15], cfg.gravity_torque, 27'h0});
            default:   grav = '0;
        endcase
    end

    assign diff      = $signed({stand[15], stand}) - $signed({st[15], st});
    assign mul1_next = $signed({1'b0, s_reg}) * diff;
    assign dpos_next = $signed({st[15], st}) - $signed({pos[15], pos});
    assign kdv_next  = $signed({1'b0, cfg.kd_gain}) * vel;
    assign err_next  = $signed({dpos_reg, 16'h0}) + mul1_reg;
    assign kpe_next  = $signed({1'b0, cfg.kp_gain}) * err_reg;

    // sum in q.36, round to nearest q8.8 with ties upward, then clamp
    assign acc   = kpe_reg - $signed({kdv_reg, 20'h0}) + grav + ROUND_HALF;
    assign t_raw = acc[55:28];
    assign lim   = $signed({13'h0, cfg.torque_limit});

    always_comb
    begin
        priority if (t_raw > lim)
        begin
            t_sat = lim[15:0];
        end
        else if (t_raw < -lim)
        begin
            t_sat = 16'(-lim);
        end
        else
        begin
            t_sat = t_raw[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            captured_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                pos_reg[waddr] <= joint_position;
                vel_reg[waddr] <= joint_velocity;
            end
            if (capture)
            begin
                captured_reg <= 1'b1;
                count_reg    <= '0;
            end
            else if (tick_start && (count_reg != 16'hFFFF))
            begin
                count_reg <= count_reg + 16'd1;
            end
        end
    end

    // start pose takes the sample written in the same transfer
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                if (wr_en && (waddr == JW'(i)))
                begin
                    start_reg[i] <= joint_position;
                end
                else
                begin
                    start_reg[i] <= pos_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_start)
        begin
            bypass_reg <= (cfg.ramp_ticks == 16'h0) || (count_reg >= cfg.ramp_ticks);
            rem_reg    <= count_reg;
            quo_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r_ge ? r_sub[15:0] : r2[15:0];
            quo_reg <= {quo_reg[14:0], r_ge};
        end
        if (cmd.calc_p2)
        begin
            p2_reg <= sq_prod[32:16];
        end
        if (cmd.calc_s)
        begin
            s_reg <= s_prod[32:16];
        end
        if (cmd.stage_a)
        begin
            mul1_reg <= mul1_next;
            dpos_reg <= dpos_next;
            kdv_reg  <= kdv_next;
        end
        if (cmd.stage_b)
        begin
            err_reg <= err_next;
        end
        if (cmd.stage_c)
        begin
            kpe_reg <= kpe_next;
        end
        if (cmd.out_load)
        begin
            out_joint_reg  <= 4'(joint_reg);
            out_torque_reg <= t_sat;
            out_last_reg   <= last_joint;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_reg     <= '0;
            part_reg      <= PART_ABDUCT;
            leg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.joint_first)
            begin
                joint_reg <= '0;
                part_reg  <= PART_ABDUCT;
                leg_reg   <= '0;
            end
            else if (cmd.out_load)
            begin
                joint_reg <= joint_reg + 1'b1;
                if (part_reg == PART_KNEE)
                begin
                    part_reg <= PART_ABDUCT;
                    leg_reg  <= leg_reg + 2'd1;
                end
                else
                begin
                    part_reg <= part_reg + 2'd1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import jpd_pkg::*;

    localparam int JOINTS        = NUM_JOINTS_DEF;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 120;
    localparam int PRINT_CAP     = 40;
    localparam int PHASE_ITEMS   = 42;

    typedef struct packed {
        logic               kind;
        logic [3:0]         joint_index;
        logic signed [15:0] position;
        logic signed [15:0] velocity;
        logic               message_end;
    } joint_item_t;

    typedef struct packed {
        logic [3:0]         joint;
        logic signed [15:0] torque;
        logic               last;
    } torque_cmd_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               sample_valid   = 1'b0;
    logic               sample_stall;
    logic               kind           = KIND_SAMPLE;
    logic [3:0]         joint_index    = '0;
    logic signed [15:0] joint_position = '0;
    logic signed [15:0] joint_velocity = '0;
    logic               message_end    = 1'b0;
    logic               result_valid;
    logic               result_stall   = 1'b0;
    logic [3:0]         torque_joint;
    logic signed [15:0] torque;
    logic               last_torque;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [4:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    joint_item_t item_feed[$];
    torque_cmd_t torque_q[$];
    joint_item_t driven_item;

    int send_idle_pct = 31;
    int recv_idle_pct = 68;
    int fault_count   = 0;
    int quiet_cycles  = 0;

    // controller mirror
    cfg_t               cfg_model;
    logic signed [15:0] pos_seen   [JOINTS];
    logic signed [15:0] vel_seen   [JOINTS];
    logic signed [15:0] pose_start [JOINTS];
    bit                 pose_held;
    int unsigned        tick_count;

    joint_pd_ramp_controller u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .kind           (kind),
        .joint_index    (joint_index),
        .joint_position (joint_position),
        .joint_velocity (joint_velocity),
        .message_end    (message_end),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .torque_joint   (torque_joint),
        .torque         (torque),
        .last_torque    (last_torque),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic apply_joint_item(input joint_item_t it);
        longint p, p2, s, stand, st, grav, cur, err, acc, t, lim;
        torque_cmd_t cmd;
        int j;
        if (it.kind == KIND_SAMPLE)
        begin
            if (it.joint_index < JOINTS)
            begin
                pos_seen[it.joint_index] = it.position;
                vel_seen[it.joint_index] = it.velocity;
            end
            if (it.message_end && !pose_held)
            begin
                pose_start = pos_seen;
                pose_held  = 1'b1;
                tick_count = 0;
            end
        end
        else if (pose_held)
        begin
            if (cfg_model.ramp_ticks == 0 || tick_count >= cfg_model.ramp_ticks)
                p = 65536;
            else
                p = (longint'(tick_count) << 16) / longint'(cfg_model.ramp_ticks);
            p2 = (p * p) >> 16;
            s  = (p2 * (196608 - 2 * p)) >> 16;
            if (tick_count < 65535)
                tick_count++;
            lim = longint'(cfg_model.torque_limit);
            for (j = 0; j < JOINTS; j++)
            begin
                case (j % 3)
                    PART_ABDUCT:
                    begin
                        // left legs are the first two of every four
                        stand = ((j / 3) % 4 < 2) ? -longint'(cfg_model.abduct_target)
                                                  : longint'(cfg_model.abduct_target);
                        grav  = 0;
                    end
                    PART_FLEX:
                    begin
                        stand = longint'($signed(cfg_model.flex_target));
                        grav  = longint'($signed(cfg_model.gravity_torque)) * 268435456;
                    end
                    default:
                    begin
                        stand = longint'($signed(cfg_model.knee_target));
                        grav  = -longint'($signed(cfg_model.gravity_torque)) * 134217728;
                    end
                endcase
                st  = longint'(pose_start[j]);
                cur = st * 65536 + s * (stand - st);
                err = cur - longint'(pos_seen[j]) * 65536;
                acc = longint'(cfg_model.kp_gain) * err
                    - longint'(cfg_model.kd_gain) * longint'(vel_seen[j]) * 1048576
                    + grav;
                // round half up, then arithmetic shift floors
                t = (acc + 134217728) >>> 28;
                if (t > lim)
                    t = lim;
                if (t < -lim)
                    t = -lim;
                cmd.joint  = 4'(j);
                cmd.torque = t[15:0];
                cmd.last   = (j == JOINTS - 1);
                torque_q.push_back(cmd);
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KP:      cfg_model.kp_gain        = value;
            REG_KD:      cfg_model.kd_gain        = value;
            REG_RAMP:    cfg_model.ramp_ticks     = value;
            REG_ABDUCT:  cfg_model.abduct_target  = value[14:0];
            REG_FLEX:    cfg_model.flex_target    = value;
            REG_KNEE:    cfg_model.knee_target    = value;
            REG_GRAVITY: cfg_model.gravity_torque = value;
            REG_LIMIT:   cfg_model.torque_limit   = value[14:0];
            default:     ;
        endcase
    endtask

    task automatic program_settings(input cfg_t c);
        write_reg(REG_KP, c.kp_gain);
        write_reg(REG_KD, c.kd_gain);
        write_reg(REG_RAMP, c.ramp_ticks);
        write_reg(REG_ABDUCT, {1'b0, c.abduct_target});
        write_reg(REG_FLEX, c.flex_target);
        write_reg(REG_KNEE, c.knee_target);
        write_reg(REG_GRAVITY, c.gravity_torque);
        write_reg(REG_LIMIT, {1'b0, c.torque_limit});
    endtask

    // every queued item taken, every torque seen, then the block's own latency
    task automatic settle();
        while (item_feed.size() != 0 || sample_valid || torque_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic joint_item_t make_item(input logic k, input int idx,
                                              input logic [15:0] pos,
                                              input logic [15:0] vel, input logic last);
        joint_item_t it;
        it.kind        = k;
        it.joint_index = 4'(idx);
        it.position    = pos;
        it.velocity    = vel;
        it.message_end = last;
        return it;
    endfunction

    function automatic joint_item_t random_item();
        joint_item_t it;
        it.kind        = ($urandom_range(99) < 22) ? KIND_TICK : KIND_SAMPLE;
        it.joint_index = ($urandom_range(9) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, JOINTS - 1));
        it.position    = ($urandom_range(1) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 12000) - 6000);
        it.velocity    = ($urandom_range(1) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 1024) - 512);
        it.message_end = ($urandom_range(11) == 0);
        return it;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.kp_gain        = ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(64, 6000));
        c.kd_gain        = ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 4000));
        c.ramp_ticks     = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
                                                    : 16'($urandom_range(1, 200));
        c.abduct_target  = ($urandom_range(3) == 0) ? 15'($urandom)
                                                    : 15'($urandom_range(0, 4000));
        c.flex_target    = ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 16000) - 8000);
        c.knee_target    = ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 16000) - 8000);
        c.gravity_torque = ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 6000) - 3000);
        c.torque_limit   = ($urandom_range(3) == 0) ? 15'($urandom)
                                                    : 15'($urandom_range(500, 20000));
        return c;
    endfunction

    // sender side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                apply_joint_item(driven_item);
            if (!(sample_valid && sample_stall))
            begin
                if (item_feed.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    driven_item     = item_feed.pop_front();
                    sample_valid   <= 1'b1;
                    kind           <= driven_item.kind;
                    joint_index    <= driven_item.joint_index;
                    joint_position <= driven_item.position;
                    joint_velocity <= driven_item.velocity;
                    message_end    <= driven_item.message_end;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // receiver side
    always @(posedge clk)
    begin : torque_check
        torque_cmd_t want;
        result_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
        if (rst_n && result_valid && !result_stall)
        begin
            if (torque_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= PRINT_CAP)
                    $display("%0t unexpected torque transfer: joint %0d torque %0d last %0b",
                             $time, torque_joint, torque, last_torque);
            end
            else
            begin
                want = torque_q.pop_front();
                if (torque_joint !== want.joint || torque !== want.torque
                    || last_torque !== want.last)
                begin
                    fault_count++;
                    if (fault_count <= PRINT_CAP)
                        $display("%0t torque mismatch: expected joint %0d torque %0d last %0b, %s",
                                 $time, want.joint, want.torque, want.last,
                                 $sformatf("got joint %0d torque %0d last %0b",
                                           torque_joint, torque, last_torque));
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("joint_pd_ramp_controller verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        cfg_t c;
        int   j;
        int   seg;
        cfg_model.kp_gain        = KP_RESET;
        cfg_model.kd_gain        = KD_RESET;
        cfg_model.ramp_ticks     = RAMP_RESET;
        cfg_model.abduct_target  = ABDUCT_RESET;
        cfg_model.flex_target    = FLEX_RESET;
        cfg_model.knee_target    = KNEE_RESET;
        cfg_model.gravity_torque = GRAVITY_RESET;
        cfg_model.torque_limit   = LIMIT_RESET;
        for (j = 0; j < JOINTS; j++)
        begin
            pos_seen[j]   = '0;
            vel_seen[j]   = '0;
            pose_start[j] = '0;
        end
        pose_held  = 1'b0;
        tick_count = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ticks before capture, field extremes, capture by a bad index,
        // repeated message ends
        item_feed.push_back(make_item(KIND_TICK, 0, 16'h0000, 16'h0000, 1'b0));
        for (j = 0; j < JOINTS; j++)
            item_feed.push_back(make_item(KIND_SAMPLE, j,
                (j == 0) ? 16'h8000 : (j == 1) ? 16'h7FFF : (j == 2) ? 16'h0000
                                    : 16'($urandom),
                (j == 0) ? 16'h7FFF : (j == 1) ? 16'h8000 : (j == 2) ? 16'hFFFF
                                    : 16'($urandom),
                1'b0));
        item_feed.push_back(make_item(KIND_SAMPLE, 12, 16'h1234, 16'h4321, 1'b0));
        item_feed.push_back(make_item(KIND_TICK, 15, 16'hFFFF, 16'hFFFF, 1'b1));
        item_feed.push_back(make_item(KIND_SAMPLE, 15, 16'h7FFF, 16'h7FFF, 1'b1));
        item_feed.push_back(make_item(KIND_TICK, 0, 16'h0000, 16'h0000, 1'b0));
        item_feed.push_back(make_item(KIND_SAMPLE, 11, 16'h8000, 16'h0100, 1'b1));
        item_feed.push_back(make_item(KIND_TICK, 0, 16'h0000, 16'h0000, 1'b0));
        item_feed.push_back(make_item(KIND_TICK, 0, 16'h0000, 16'h0000, 1'b0));
        item_feed.push_back(make_item(KIND_SAMPLE, 13, 16'h0400, 16'hFF00, 1'b1));
        item_feed.push_back(make_item(KIND_TICK, 0, 16'h0000, 16'h0000, 1'b0));
        settle();

        // random at reset settings, with a full drain in the middle
        repeat (50) item_feed.push_back(random_item());
        settle();
        repeat (30) item_feed.push_back(random_item());
        settle();

        for (seg = 0; seg < 9; seg++)
        begin
            case (seg)
                0:
                begin
                    c.kp_gain        = 16'hFFFF;
                    c.kd_gain        = 16'hFFFF;
                    c.ramp_ticks     = 16'hFFFF;
                    c.abduct_target  = 15'h7FFF;
                    c.flex_target    = 16'h7FFF;
                    c.knee_target    = 16'h8000;
                    c.gravity_torque = 16'h7FFF;
                    c.torque_limit   = 15'h7FFF;
                end
                1:
                begin
                    c.kp_gain        = 16'h0000;
                    c.kd_gain        = 16'h0000;
                    c.ramp_ticks     = 16'h0001;
                    c.abduct_target  = 15'h0000;
                    c.flex_target    = 16'h8000;
                    c.knee_target    = 16'h7FFF;
                    c.gravity_torque = 16'h8000;
                    c.torque_limit   = 15'h0000;
                end
                2:
                begin
                    // zero ramp length means full progress at once
                    c            = random_settings();
                    c.ramp_ticks = 16'h0000;
                end
                default:
                begin
                    c = random_settings();
                end
            endcase
            if (seg >= 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (seg >= 3)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 31;
            end
            program_settings(c);
            repeat (PHASE_ITEMS) item_feed.push_back(random_item());
            settle();
        end

        if (fault_count == 0)
            $display("joint_pd_ramp_controller verification clean");
        else
            $display("joint_pd_ramp_controller verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/jpd_pkg.sv
src/jpd_regs.sv
src/jpd_ctrl.sv
src/jpd_datapath.sv
src/joint_pd_ramp_controller.sv
tb/tb.sv
